[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEF_DEPTH      = 1024;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_MAX_POP    = 64;

    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 10;
    localparam int FILL_W  = 11;
    localparam int STAT_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_READ       = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  push_data;
        logic [COUNT_W-1:0] pop_count;
        logic [INDEX_W-1:0] read_index;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [STAT_W-1:0] status;
        logic              last;
        logic [FILL_W-1:0] fill_level;
    } t_result;

endpackage

[design/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue held in a circular ram with head pointer and fill count
// ----------------------------------------------------------------------------
// push or error: result beat on the cycle after the command, busy stays low
// read at index: the ram read is registered, then its data is registered as a
//   beat; busy while in S_DRAIN, so the next command is taken as that beat ends
// pop of n words: one ram read per cycle, n beats back to back, first beat after
//   S_POP, ram read and result register; busy to S_DRAIN; receiver cannot stall
// reset clears head pointer, fill count and control; ram content is not cleared
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int MAX_POP    = DEF_MAX_POP
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    // stored bits: the result field carries at most DATA_W bits
    localparam int STORE_W = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DRAIN
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [COUNT_W-1:0]  r_left;
    logic                r_back;
    // pending ram read whose data turns into a result beat next cycle
    logic                r_pend;
    logic                r_pend_last;
    logic [CW-1:0]       r_pend_fill;
    logic                r_strobe;
    t_result             r_result;

    logic                accept;
    logic                full;
    logic [AW-1:0]       head_dec;
    logic [AW-1:0]       head_inc;
    logic [COUNT_W-1:0]  pop_clamp;
    logic [COUNT_W-1:0]  pop_n;
    logic                idx_ok;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [STORE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [STORE_W-1:0]  ram_rdata;

    // logical position to physical slot, position is below DEPTH
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW:0]   pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + pos;
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign full     = (32'(r_count) >= 32'(DEPTH));
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (32'(r_head) == 32'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign idx_ok   = (32'(i_cmd.read_index) < 32'(r_count));

    // clamp the pop to MAX_POP and then to the fill level
    always_comb begin
        pop_clamp = i_cmd.pop_count;
        if (32'(i_cmd.pop_count) > 32'(MAX_POP)) begin
            pop_clamp = COUNT_W'(MAX_POP);
        end
        pop_n = pop_clamp;
        if (32'(r_count) < 32'(pop_clamp)) begin
            pop_n = COUNT_W'(r_count);
        end
    end

    // ram ports: writes only on an accepted push, reads on read or pop
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = head_dec;
        ram_wdata = i_cmd.push_data[STORE_W-1:0];
        ram_re    = 1'b0;
        ram_raddr = slot_of(r_head, (AW+1)'(i_cmd.read_index));
        case (r_state)
            S_IDLE: begin
                if (accept && !full) begin
                    if (i_cmd.kind == K_PUSH_FRONT) begin
                        ram_we = 1'b1;
                    end else if (i_cmd.kind == K_PUSH_BACK) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_of(r_head, (AW+1)'(r_count));
                    end
                end
                if (accept && i_cmd.kind == K_READ && idx_ok) begin
                    ram_re = 1'b1;
                end
            end
            S_POP: begin
                ram_re = 1'b1;
                if (r_back) begin
                    ram_raddr = slot_of(r_head, (AW+1)'(r_count - CW'(1)));
                end else begin
                    ram_raddr = r_head;
                end
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    deq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_left   <= '0;
            r_back   <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;

            // ram data from last cycle's read leaves as a beat
            if (r_pend) begin
                r_strobe            <= 1'b1;
                r_result.read_data  <= DATA_W'(ram_rdata);
                r_result.status     <= ST_OK;
                r_result.last       <= r_pend_last;
                r_result.fill_level <= FILL_W'(r_pend_fill);
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_result.read_data  <= '0;
                        r_result.last       <= 1'b1;
                        r_result.fill_level <= FILL_W'(r_count);
                        case (i_cmd.kind)
                            K_PUSH_FRONT, K_PUSH_BACK: begin
                                r_strobe <= 1'b1;
                                if (full) begin
                                    r_result.status <= ST_FULL;
                                end else begin
                                    r_result.status     <= ST_OK;
                                    r_result.fill_level <= FILL_W'(r_count + CW'(1));
                                    r_count             <= r_count + CW'(1);
                                    if (i_cmd.kind == K_PUSH_FRONT) begin
                                        r_head <= head_dec;
                                    end
                                end
                            end
                            K_POP_FRONT, K_POP_BACK: begin
                                if (pop_n == '0) begin
                                    r_strobe        <= 1'b1;
                                    r_result.status <= ST_EMPTY;
                                end else begin
                                    r_left  <= pop_n;
                                    r_back  <= (i_cmd.kind == K_POP_BACK);
                                    r_state <= S_POP;
                                end
                            end
                            K_READ: begin
                                if (idx_ok) begin
                                    r_pend      <= 1'b1;
                                    r_pend_last <= 1'b1;
                                    r_pend_fill <= r_count;
                                    r_state     <= S_DRAIN;
                                end else begin
                                    r_strobe        <= 1'b1;
                                    r_result.status <= ST_RANGE;
                                end
                            end
                            default: begin
                                // unused kinds give no beat
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    // one word leaves per cycle
                    r_pend      <= 1'b1;
                    r_pend_last <= (r_left == COUNT_W'(1));
                    r_pend_fill <= r_count - CW'(1);
                    r_count     <= r_count - CW'(1);
                    r_left      <= r_left - COUNT_W'(1);
                    if (!r_back) begin
                        r_head <= head_inc;
                    end
                    if (r_left == COUNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // fill count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH))
        else $error("fill count above capacity");

    // a pop in flight always has a word to take
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_left != '0) && (r_count != '0))
        else $error("pop issued on empty store");

    // error beats always close their command
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |-> o_result.last)
        else $error("error beat without last");

    // beats of one pop come back to back
    a_pop_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("gap inside a pop burst");

    // a push with room answers ok on the next cycle
    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full && (i_cmd.kind == K_PUSH_FRONT || i_cmd.kind == K_PUSH_BACK))
        |=> (o_strobe && o_result.status == ST_OK && o_result.last))
        else $error("push result missing");

endmodule
